@@ rtl/mbad_pkg.sv @@
// ----------------------------------------------------------------------------
// mbad_pkg
// Shared types and constants for the masked block average downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mbad_pkg;

   // Default log2 of the largest block side.
   localparam int MAX_BLOCK_LOG_DEF = 8;

   // Channel count and channel byte width.
   localparam int CHANNELS = 4;
   localparam int PIX_W    = 8;

   // Quotient bits produced by the divider, one per step.
   localparam int QUOT_W = PIX_W;
   localparam int STEP_W = $clog2(QUOT_W);

   // Incoming pixel of one block.
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] alpha;
      logic             covered;
      logic             block_end;
   } req_data_type;

   // Averaged pixel of one block.
   typedef struct packed {
      logic [PIX_W-1:0] avg_blue;
      logic [PIX_W-1:0] avg_green;
      logic [PIX_W-1:0] avg_red;
      logic [PIX_W-1:0] avg_alpha;
      logic             from_covered;
   } rsp_data_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accum;     // a request is accepted this cycle
      logic start;     // the accepted request closes a block
      logic step;      // one divider step
      logic load_out;  // move quotients to the output register
   } mbad_cmd_type;

endpackage : mbad_pkg

`default_nettype wire

@@ rtl/mbad_ctrl.sv @@
// ----------------------------------------------------------------------------
// mbad_ctrl
// Controller: request acceptance, divider sequencing and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mbad_ctrl
   import mbad_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_block_end,
   output      logic         req_stall,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      mbad_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_take;
   logic              rsp_take;
   logic              out_free;

   // A block end waits while the divider still holds the previous block.
   assign req_stall = req_block_end && (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || rsp_take;
   assign rsp_valid = rsp_valid_ff;

   // Next state, step counter and datapath commands.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.accum    = req_take;
      cmd.start    = req_take && req_block_end;
      cmd.step     = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (cmd.start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid sets on a load and clears when the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule : mbad_ctrl

`default_nettype wire

@@ rtl/mbad_dp.sv @@
// ----------------------------------------------------------------------------
// mbad_dp
// Datapath: covered and uncovered accumulators, a four-lane restoring
// divider that yields one quotient bit per step, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbad_dp
   import mbad_pkg::*;
#(
   parameter int MAX_BLOCK_LOG = MAX_BLOCK_LOG_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire mbad_cmd_type cmd,
   input  wire req_data_type req_data,
   output      rsp_data_type rsp_data
);

   localparam int CNT_W = 2 * MAX_BLOCK_LOG + 1;
   localparam int SUM_W = CNT_W + QUOT_W - 1;
   localparam logic [CNT_W:0] CAPACITY = (CNT_W + 1)'(1) << (2 * MAX_BLOCK_LOG);

   logic [SUM_W-1:0]  cov_sum_ff [CHANNELS];
   logic [SUM_W-1:0]  unc_sum_ff [CHANNELS];
   logic [SUM_W-1:0]  cov_sum_nx [CHANNELS];
   logic [SUM_W-1:0]  unc_sum_nx [CHANNELS];
   logic [CNT_W-1:0]  cov_cnt_ff, unc_cnt_ff;
   logic [CNT_W-1:0]  cov_cnt_nx, unc_cnt_nx;
   logic [PIX_W-1:0]  pix [CHANNELS];
   logic [CNT_W:0]    total;
   logic              add_ok;
   logic              use_cov;
   logic [CNT_W-1:0]  n_sel;

   logic [SUM_W-1:0]  rem_ff [CHANNELS];
   logic [SUM_W-1:0]  rem_in [CHANNELS];
   logic [QUOT_W-1:0] quo_ff [CHANNELS];
   logic [QUOT_W-1:0] quo_in [CHANNELS];
   logic [SUM_W-1:0]  div_ff, div_in;
   logic              from_cov_ff, from_cov_in;
   logic              zero_ff, zero_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;

   assign pix[0] = req_data.blue;
   assign pix[1] = req_data.green;
   assign pix[2] = req_data.red;
   assign pix[3] = req_data.alpha;

   // Accumulate the pixel unless the block is already at capacity.
   always_comb begin
      total      = {1'b0, cov_cnt_ff} + {1'b0, unc_cnt_ff};
      add_ok     = cmd.accum && (total < CAPACITY);
      cov_cnt_nx = cov_cnt_ff;
      unc_cnt_nx = unc_cnt_ff;
      if (add_ok && req_data.covered) begin
         cov_cnt_nx = cov_cnt_ff + CNT_W'(1);
      end
      if (add_ok && !req_data.covered) begin
         unc_cnt_nx = unc_cnt_ff + CNT_W'(1);
      end
      for (int c = 0; c < CHANNELS; c++) begin
         cov_sum_nx[c] = cov_sum_ff[c];
         unc_sum_nx[c] = unc_sum_ff[c];
         if (add_ok && req_data.covered) begin
            cov_sum_nx[c] = cov_sum_ff[c] + SUM_W'(pix[c]);
         end
         if (add_ok && !req_data.covered) begin
            unc_sum_nx[c] = unc_sum_ff[c] + SUM_W'(pix[c]);
         end
      end
      use_cov = (cov_cnt_nx != '0);
      n_sel   = use_cov ? cov_cnt_nx : unc_cnt_nx;
   end

   // Accumulators clear when a block closes.
   always_ff @(posedge clock) begin
      if (reset || cmd.start) begin
         cov_cnt_ff <= '0;
         unc_cnt_ff <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            cov_sum_ff[c] <= '0;
            unc_sum_ff[c] <= '0;
         end
      end else begin
         cov_cnt_ff <= cov_cnt_nx;
         unc_cnt_ff <= unc_cnt_nx;
         for (int c = 0; c < CHANNELS; c++) begin
            cov_sum_ff[c] <= cov_sum_nx[c];
            unc_sum_ff[c] <= unc_sum_nx[c];
         end
      end
   end

   // Divider: the divisor starts shifted up by the quotient width less one
   // and moves down one bit per step; each lane subtracts where it fits.
   // The quotient never exceeds a channel byte, so eight steps suffice.
   always_comb begin
      div_in      = div_ff;
      from_cov_in = from_cov_ff;
      zero_in     = zero_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         rem_in[c] = rem_ff[c];
         quo_in[c] = quo_ff[c];
      end
      if (cmd.start) begin
         div_in      = {n_sel, {(QUOT_W - 1){1'b0}}};
         from_cov_in = use_cov;
         zero_in     = (n_sel == '0);
         for (int c = 0; c < CHANNELS; c++) begin
            rem_in[c] = use_cov ? cov_sum_nx[c] : unc_sum_nx[c];
            quo_in[c] = '0;
         end
      end else if (cmd.step) begin
         div_in = div_ff >> 1;
         for (int c = 0; c < CHANNELS; c++) begin
            if (rem_ff[c] >= div_ff) begin
               rem_in[c] = rem_ff[c] - div_ff;
               quo_in[c] = {quo_ff[c][QUOT_W-2:0], 1'b1};
            end else begin
               quo_in[c] = {quo_ff[c][QUOT_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff      <= div_in;
      from_cov_ff <= from_cov_in;
      zero_ff     <= zero_in;
      for (int c = 0; c < CHANNELS; c++) begin
         rem_ff[c] <= rem_in[c];
         quo_ff[c] <= quo_in[c];
      end
   end

   // Output register; an empty block averages to zero.
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_data_in.avg_blue     = zero_ff ? '0 : quo_ff[0];
         rsp_data_in.avg_green    = zero_ff ? '0 : quo_ff[1];
         rsp_data_in.avg_red      = zero_ff ? '0 : quo_ff[2];
         rsp_data_in.avg_alpha    = zero_ff ? '0 : quo_ff[3];
         rsp_data_in.from_covered = from_cov_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule : mbad_dp

`default_nettype wire

@@ rtl/masked_block_average_downsample.sv @@
// ----------------------------------------------------------------------------
// masked_block_average_downsample: masked box-filter downsampler
// Pixels are accepted one per cycle; a block end is accepted only while the
// divider is free, and its average is valid after 8 divider steps and a load
// that waits for a free output register; only then can a new block end enter.
// Reset clears the accumulators, the controller and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_block_average_downsample
   import mbad_pkg::*;
#(
   parameter int MAX_BLOCK_LOG = MAX_BLOCK_LOG_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_data_type req_data,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_data_type rsp_data
);

   mbad_cmd_type cmd;

   // Sequencer for acceptance, division and output.
   mbad_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_block_end (req_data.block_end),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd)
   );

   // Accumulators, divider and output register.
   mbad_dp #(
      .MAX_BLOCK_LOG (MAX_BLOCK_LOG)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule : masked_block_average_downsample

`default_nettype wire

@@ sim/masked_block_average_downsample_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_block_average_downsample_test: block average downsampler testbench
// Streams pixel blocks into the downsampler and keeps a running copy of the
// covered and uncovered sums. Each block end produces one expected average,
// and every average that leaves the block is compared against it field by
// field. The run covers a short directed set of blocks, block ends sent back
// to back, and then random blocks.
// Requests arrive in random bursts and the output side stalls at random,
// including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------

module masked_block_average_downsample_test;
   import mbad_pkg::*;

   localparam int SUM_W            = 2 * MAX_BLOCK_LOG_DEF + PIX_W;
   localparam int CNT_W            = 2 * MAX_BLOCK_LOG_DEF + 1;
   localparam int BLOCK_CAPACITY   = 1 << (2 * MAX_BLOCK_LOG_DEF);
   localparam int RANDOM_PIXELS    = 400;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int TAIL_CYCLES      = 20;
   localparam int MAX_PRINTED      = 20;

   typedef enum {COVER_ALL, COVER_NONE, COVER_MIXED, COVER_SPARSE} cover_mode_type;
   typedef enum {VALUES_FULL, VALUES_EXTREME, VALUES_LOW} value_mode_type;
   typedef enum {STALL_NEVER, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   // Running sums of the current block and the averages still owed by the block.
   class block_average_tracker_type;
      bit [SUM_W-1:0] covered_sum[CHANNELS];
      bit [SUM_W-1:0] uncovered_sum[CHANNELS];
      bit [CNT_W-1:0] covered_cnt;
      bit [CNT_W-1:0] uncovered_cnt;
      rsp_data_type   pending_averages[$];
      string          channel_names[CHANNELS] = '{"blue", "green", "red", "alpha"};
      int             mismatches;
      int             averages_checked;
      int             dropped_pixels;

      // Accumulate one accepted pixel; a block end yields one expected average.
      function void note_pixel(req_data_type px);
         bit [PIX_W-1:0] chan[CHANNELS];
         bit [SUM_W-1:0] quot[CHANNELS];
         bit [CNT_W-1:0] n;
         bit             use_covered;
         rsp_data_type   avg;
         chan = '{px.blue, px.green, px.red, px.alpha};
         // Pixels beyond the block capacity are ignored, but a block end still counts.
         if (int'(covered_cnt) + int'(uncovered_cnt) < BLOCK_CAPACITY) begin
            for (int c = 0; c < CHANNELS; c++) begin
               if (px.covered) covered_sum[c] += SUM_W'(chan[c]);
               else uncovered_sum[c] += SUM_W'(chan[c]);
            end
            if (px.covered) covered_cnt++;
            else uncovered_cnt++;
         end else begin
            dropped_pixels++;
         end
         if (!px.block_end) return;
         // Covered pixels win whenever the block has any.
         use_covered = (covered_cnt != 0);
         n = use_covered ? covered_cnt : uncovered_cnt;
         for (int c = 0; c < CHANNELS; c++) begin
            quot[c] = (n != 0) ? (use_covered ? covered_sum[c] : uncovered_sum[c]) / n : '0;
         end
         avg.avg_blue     = quot[0][PIX_W-1:0];
         avg.avg_green    = quot[1][PIX_W-1:0];
         avg.avg_red      = quot[2][PIX_W-1:0];
         avg.avg_alpha    = quot[3][PIX_W-1:0];
         avg.from_covered = use_covered;
         pending_averages.insert(pending_averages.size(), avg);
         covered_sum   = '{default: '0};
         uncovered_sum = '{default: '0};
         covered_cnt   = '0;
         uncovered_cnt = '0;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      // Compare one accepted average with the oldest one owed.
      task check_average(rsp_data_type got);
         rsp_data_type   want;
         logic [PIX_W-1:0] got_ch[CHANNELS];
         logic [PIX_W-1:0] want_ch[CHANNELS];
         if (pending_averages.size() == 0) begin
            report_mismatch($sformatf("average %p with no block end pending", got));
            return;
         end
         want = pending_averages.pop_front();
         averages_checked++;
         got_ch  = '{got.avg_blue, got.avg_green, got.avg_red, got.avg_alpha};
         want_ch = '{want.avg_blue, want.avg_green, want.avg_red, want.avg_alpha};
         for (int c = 0; c < CHANNELS; c++) begin
            if (got_ch[c] !== want_ch[c])
               report_mismatch($sformatf("average %0d %s: got %0d, expected %0d",
                                         averages_checked, channel_names[c],
                                         got_ch[c], want_ch[c]));
         end
         if (got.from_covered !== want.from_covered)
            report_mismatch($sformatf("average %0d from_covered: got %b, expected %b",
                                      averages_checked, got.from_covered,
                                      want.from_covered));
      endtask
   endclass

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_data_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_data_type rsp_data;

   block_average_tracker_type tracker = new();

   int pixels_sent;
   int blocks_sent;
   int burst_left;
   bit idling_on;
   bit hold_off_pending;

   masked_block_average_downsample DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watch both channels and feed the tracker.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_pixel(req_data);
         if (rsp_valid && !rsp_stall) tracker.check_average(rsp_data);
      end
   end

   // End the run if nothing moves on either channel for too long.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Timeout: no request or average moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Output side: stall pattern whose mode is redrawn at random,
   // plus one long hold-off when the stimulus asks for it.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             phase;
      bit             stall_now;
      mode_left = 0;
      phase     = 0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 80);
            end
            case (mode)
               STALL_NEVER:  stall_now = 1'b0;
               STALL_LIGHT:  stall_now = ($urandom_range(0, 3) == 0);
               STALL_HEAVY:  stall_now = ($urandom_range(0, 3) != 0);
               default:      stall_now = phase[0];
            endcase
            phase++;
            mode_left--;
            rsp_stall <= stall_now;
            @(posedge clock);
         end
      end
   end

   function automatic req_data_type pixel(bit [PIX_W-1:0] b, bit [PIX_W-1:0] g,
                                          bit [PIX_W-1:0] r, bit [PIX_W-1:0] a,
                                          bit cov, bit last);
      req_data_type px;
      px.blue      = b;
      px.green     = g;
      px.red       = r;
      px.alpha     = a;
      px.covered   = cov;
      px.block_end = last;
      return px;
   endfunction

   function automatic req_data_type random_pixel(bit cov, bit last, value_mode_type vm);
      bit [PIX_W-1:0] chan[CHANNELS];
      for (int c = 0; c < CHANNELS; c++) begin
         case (vm)
            VALUES_FULL:    chan[c] = PIX_W'($urandom_range(0, 255));
            VALUES_EXTREME: chan[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:        chan[c] = PIX_W'($urandom_range(0, 3));
         endcase
      end
      return pixel(chan[0], chan[1], chan[2], chan[3], cov, last);
   endfunction

   // Offer one request and wait until it is taken. When idling is on, the
   // sender works in bursts with a random gap before each burst.
   task send_pixel(req_data_type px);
      int gap;
      if (idling_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_data  <= px;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task send_block(int size, cover_mode_type cm, value_mode_type vm);
      bit cov;
      for (int i = 0; i < size; i++) begin
         case (cm)
            COVER_ALL:   cov = 1'b1;
            COVER_NONE:  cov = 1'b0;
            COVER_MIXED: cov = 1'($urandom_range(0, 1));
            default:     cov = ($urandom_range(0, 7) == 0);
         endcase
         send_pixel(random_pixel(cov, i == size - 1, vm));
      end
      blocks_sent++;
   endtask

   // Main stimulus.
   initial begin
      int             size_pick;
      int             block_size;
      cover_mode_type cm;
      value_mode_type vm;
      idling_on        = 1'b1;
      burst_left       = 0;
      hold_off_pending = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: one-pixel blocks at both extremes.
      send_pixel(pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1));
      send_pixel(pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
      // Mixed block: only the covered pixels are averaged.
      send_pixel(pixel(8'd10, 8'd20, 8'd30, 8'd40, 1'b0, 1'b0));
      send_pixel(pixel(8'd200, 8'd100, 8'd50, 8'd25, 1'b1, 1'b0));
      send_pixel(pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
      send_pixel(pixel(8'd101, 8'd3, 8'd0, 8'd255, 1'b1, 1'b1));
      // No covered pixel: the uncovered ones are averaged, with truncation.
      send_pixel(pixel(8'd255, 8'd0, 8'd1, 8'd2, 1'b0, 1'b0));
      send_pixel(pixel(8'd254, 8'd0, 8'd2, 8'd2, 1'b0, 1'b0));
      send_pixel(pixel(8'd0, 8'd255, 8'd0, 8'd3, 1'b0, 1'b1));
      // A dark covered pixel beats bright padding.
      send_pixel(pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0));
      send_pixel(pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
      send_pixel(pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b1));
      // Covered pair whose averages truncate.
      send_pixel(pixel(8'd1, 8'd2, 8'd3, 8'd254, 1'b1, 1'b0));
      send_pixel(pixel(8'd2, 8'd2, 8'd4, 8'd255, 1'b1, 1'b1));
      blocks_sent += 6;
      // Block ends back to back, to find the divider busy.
      idling_on = 1'b0;
      repeat (4) send_block(1, COVER_MIXED, VALUES_FULL);

      // Random blocks, mostly small, starting with a long output hold-off.
      hold_off_pending = 1'b1;
      idling_on        = 1'b1;
      pixels_sent      = 0;
      while (pixels_sent < RANDOM_PIXELS) begin
         size_pick = $urandom_range(0, 99);
         if (size_pick < 60) block_size = $urandom_range(1, 4);
         else if (size_pick < 85) block_size = $urandom_range(5, 16);
         else if (size_pick < 97) block_size = $urandom_range(17, 64);
         else block_size = 256;
         cm        = cover_mode_type'($urandom_range(0, 3));
         vm        = value_mode_type'($urandom_range(0, 2));
         idling_on = ($urandom_range(0, 4) != 0);
         send_block(block_size, cm, vm);
      end
      req_valid <= 1'b0;

      // Drain the remaining averages, then allow for any stray output.
      while (tracker.pending_averages.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d blocks: directed cases, back-to-back block ends and",
               blocks_sent);
      $display("%0d random pixels; %0d averages checked, %0d pixels ignored, %0d mismatches.",
               pixels_sent, tracker.averages_checked, tracker.dropped_pixels,
               tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/mbad_pkg.sv
rtl/mbad_ctrl.sv
rtl/mbad_dp.sv
rtl/masked_block_average_downsample.sv
sim/masked_block_average_downsample_test.sv
